### src/i2cmw_pkg.sv
// Shared types and constants for the bit-banged I2C master write sequencer.
package i2cmw_pkg;

	localparam int HOLD_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int BIT_IDX_W  = 3;
	localparam int SUB_W      = 2;
	localparam int SECT_W     = 3;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd8;

	// Sequencer sections, also the state codes of the sequencer
	localparam logic [SECT_W-1:0] SECT_IDLE  = 3'd0;
	localparam logic [SECT_W-1:0] SECT_START = 3'd1;
	localparam logic [SECT_W-1:0] SECT_BITS  = 3'd2;
	localparam logic [SECT_W-1:0] SECT_ACK   = 3'd3;
	localparam logic [SECT_W-1:0] SECT_STOP  = 3'd4;

	// Last sub-phase of each section
	localparam logic [SUB_W-1:0] SUB_START_LAST = 2'd1;
	localparam logic [SUB_W-1:0] SUB_BIT_LAST   = 2'd2;
	localparam logic [SUB_W-1:0] SUB_ACK_LAST   = 2'd1;
	localparam logic [SUB_W-1:0] SUB_STOP_LAST  = 2'd3;

	// Where the sequencer stands in the phase run
	typedef struct packed {
		logic [SECT_W-1:0] sect;
		logic [SUB_W-1:0]  sub;
		logic              data_bit;   // bit currently on the wire
		logic              sda_latch;  // level left on SDA by the last data bit
		logic              want_stop;
	} phase_pos_t;

	// One bus phase
	typedef struct packed {
		logic last;
		logic rel;
		logic sda;
		logic scl;
	} pins_t;

endpackage

### src/i2cmw_hold_timer.sv
// Phase hold timer: down counter that paces the emitted bus phases.
module i2cmw_hold_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [i2cmw_pkg::HOLD_W-1:0]   load_value,
	output logic                           done
);
	import i2cmw_pkg::*;

	logic [HOLD_W-1:0] cnt_q;

	// Count down to zero; a load restarts the hold period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_value;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - HOLD_W'(1);
		end
	end

	// Next phase may go once the count has reached one or zero
	assign done = (cnt_q <= HOLD_W'(1));

endmodule

### src/i2cmw_phase_dec.sv
// Phase decoder: pin levels of the bus phase at the current sequencer position.
module i2cmw_phase_dec (
	input  i2cmw_pkg::phase_pos_t pos,
	output i2cmw_pkg::pins_t      pins
);
	import i2cmw_pkg::*;

	always_comb begin
		pins = '0;
		unique case (pos.sect)
			SECT_START: begin
				// SDA falls with SCL high, then SCL falls
				pins.scl  = (pos.sub == '0);
				pins.sda  = 1'b0;
			end
			SECT_BITS: begin
				// data set with SCL low, SCL high, SCL low
				pins.scl  = (pos.sub == 2'd1);
				pins.sda  = pos.data_bit;
			end
			SECT_ACK: begin
				if (pos.sub == '0) begin
					pins.scl = 1'b1;
					pins.sda = 1'b1;
					pins.rel = 1'b1;
				end else begin
					pins.scl  = 1'b0;
					pins.sda  = pos.sda_latch;
					pins.last = !pos.want_stop;
				end
			end
			SECT_STOP: begin
				case (pos.sub)
					2'd0: begin
						pins.scl = 1'b0;
						pins.sda = pos.sda_latch;
					end
					2'd1: begin
						pins.scl = 1'b0;
						pins.sda = 1'b0;
					end
					2'd2: begin
						pins.scl = 1'b1;
						pins.sda = 1'b0;
					end
					default: begin
						pins.scl  = 1'b1;
						pins.sda  = 1'b1;
						pins.last = 1'b1;
					end
				endcase
			end
			default: begin
				pins = '0;
			end
		endcase
	end

endmodule

### src/i2c_master_write_bitbang_top.sv
// Top level of the bit-banged I2C master write phase sequencer.
// Each accepted byte turns into a run of bus phases on the output stream, one transfer per
// phase: 2 for a start condition (only when the bus is idle), 24 for the byte MSB first at
// 3 per bit, 2 for the acknowledge slot (SDA released in the first) and 4 for a stop, so 26 to
// 32 phases per byte; tlast marks the final phase of the byte. A byte that arrives on an idle
// bus without a start request is dropped with no output. A start request on an open transfer
// is ignored. The sequencer emits one phase per step and a 16-bit hold timer, loaded from
// phase_hold_cycles (reset value 8, written through the cfg channel), paces successive phases;
// a phase goes only once the timer has run out and the output register is free or being read.
// A new byte is taken once its predecessor's final phase sits in the output register. The
// acknowledge bit from the slave is not sampled.
module i2c_master_write_bitbang_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: phase_hold_cycles
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Input bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [0] send_start, [1] send_stop
	// Bus phases
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] scl_level, [1] sda_level, [2] sda_released, [7:3] zero
	output logic        m_tlast    // last_phase
);
	import i2cmw_pkg::*;

	logic [HOLD_W-1:0]    hold_q;
	logic [SECT_W-1:0]    state_q;
	logic [SUB_W-1:0]     sub_q;
	logic [BIT_IDX_W-1:0] bit_q;
	logic [BYTE_W-1:0]    shreg_q;
	logic                 sda_latch_q;
	logic                 stop_q;
	logic                 open_q;
	logic                 out_valid_q;
	pins_t                out_pins_q;

	logic       in_xfer;
	logic       tmr_done;
	logic       emit;
	phase_pos_t pos;
	pins_t      pins;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_q <= cfg_data;
		end
	end

	// Handshakes and phase pacing
	assign s_tready = (state_q == SECT_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign emit     = (state_q != SECT_IDLE) && tmr_done && (!out_valid_q || m_tready);

	i2cmw_hold_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (emit),
		.load_value (hold_q),
		.done       (tmr_done)
	);

	// Current position into the phase decoder
	always_comb begin
		pos.sect      = state_q;
		pos.sub       = sub_q;
		pos.data_bit  = shreg_q[BYTE_W-1];
		pos.sda_latch = sda_latch_q;
		pos.want_stop = stop_q;
	end

	i2cmw_phase_dec u_dec (
		.pos  (pos),
		.pins (pins)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SECT_IDLE;
			sub_q       <= '0;
			bit_q       <= '0;
			sda_latch_q <= 1'b1;
			stop_q      <= 1'b0;
			open_q      <= 1'b0;
		end else begin
			unique case (state_q)
				SECT_IDLE: begin
					if (in_xfer && (open_q || s_tuser[0])) begin
						state_q <= open_q ? SECT_BITS : SECT_START;
						sub_q   <= '0;
						bit_q   <= '0;
						stop_q  <= s_tuser[1];
						open_q  <= 1'b1;
					end
				end
				SECT_START: begin
					if (emit) begin
						if (sub_q == SUB_START_LAST) begin
							state_q <= SECT_BITS;
							sub_q   <= '0;
						end else begin
							sub_q <= sub_q + SUB_W'(1);
						end
					end
				end
				SECT_BITS: begin
					if (emit) begin
						if (sub_q == SUB_BIT_LAST) begin
							sub_q       <= '0;
							sda_latch_q <= shreg_q[BYTE_W-1];
							bit_q       <= bit_q + BIT_IDX_W'(1);
							if (bit_q == '1) begin
								state_q <= SECT_ACK;
							end
						end else begin
							sub_q <= sub_q + SUB_W'(1);
						end
					end
				end
				SECT_ACK: begin
					if (emit) begin
						if (sub_q == SUB_ACK_LAST) begin
							sub_q   <= '0;
							state_q <= stop_q ? SECT_STOP : SECT_IDLE;
						end else begin
							sub_q <= sub_q + SUB_W'(1);
						end
					end
				end
				SECT_STOP: begin
					if (emit) begin
						if (sub_q == SUB_STOP_LAST) begin
							sub_q       <= '0;
							state_q     <= SECT_IDLE;
							open_q      <= 1'b0;
							sda_latch_q <= 1'b1;
						end else begin
							sub_q <= sub_q + SUB_W'(1);
						end
					end
				end
				default: begin
					state_q <= SECT_IDLE;
				end
			endcase
		end
	end

	// Byte shifter, MSB goes out first
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			shreg_q <= s_tdata;
		end else if (emit && state_q == SECT_BITS && sub_q == SUB_BIT_LAST) begin
			shreg_q <= {shreg_q[BYTE_W-2:0], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pins_q <= pins;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_pins_q.rel, out_pins_q.sda, out_pins_q.scl};
	assign m_tlast  = out_pins_q.last;

	// Checks
	property p_drop_idle;
		@(posedge clk) disable iff (!arst_n)
		(in_xfer && !open_q && !s_tuser[0]) |=> (state_q == SECT_IDLE);
	endproperty
	a_drop_idle: assert property (p_drop_idle) else $error("dropped byte started a run");

	property p_last_to_idle;
		@(posedge clk) disable iff (!arst_n)
		(emit && pins.last) |=> (state_q == SECT_IDLE);
	endproperty
	a_last_to_idle: assert property (p_last_to_idle) else $error("run went on after last phase");

	property p_close_on_stop;
		@(posedge clk) disable iff (!arst_n)
		$fell(open_q) |-> $past(state_q == SECT_STOP);
	endproperty
	a_close_on_stop: assert property (p_close_on_stop) else $error("transfer closed without stop");

	property p_rel_scl_high;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[0] && !m_tlast);
	endproperty
	a_rel_scl_high: assert property (p_rel_scl_high) else $error("SDA released with SCL low");

endmodule

### bench/i2c_master_write_bitbang_top_tb.sv
// Self-checking bench for the bit-banged I2C master write phase sequencer.
`timescale 1ns / 100ps

module i2c_master_write_bitbang_top_tb;

	import i2cmw_pkg::*;

	// One expected bus phase; the per-byte count is only checked on typed rows
	typedef struct packed {
		pins_t      pins;
		logic       typed;
		logic [7:0] typed_len;
	} phase_exp_t;

	// Directed stimulus row
	typedef struct packed {
		logic [7:0] data_byte;
		logic       send_start;
		logic       send_stop;
		logic       typed;
		logic [7:0] typed_len;
		pins_t      typed_tail;
	} byte_row_t;

	// Final phase after a stop, and after a byte left open on a low or high data bit
	localparam pins_t TAIL_STOP  = '{last: 1'b1, rel: 1'b0, sda: 1'b1, scl: 1'b1};
	localparam pins_t TAIL_OPEN0 = '{last: 1'b1, rel: 1'b0, sda: 1'b0, scl: 1'b0};
	localparam pins_t TAIL_OPEN1 = '{last: 1'b1, rel: 1'b0, sda: 1'b1, scl: 1'b0};
	localparam pins_t TAIL_NONE  = '{last: 1'b0, rel: 1'b0, sda: 1'b0, scl: 1'b0};

	localparam int N_DIRECTED = 17;
	localparam byte_row_t DIRECTED [N_DIRECTED] = '{
		'{8'hA5, 1'b0, 1'b1, 1'b1, 8'd0,  TAIL_NONE},  // idle, no start: dropped
		'{8'h00, 1'b1, 1'b0, 1'b1, 8'd28, TAIL_OPEN0}, // start actually issued: 2 + 24 + 2
		'{8'hFF, 1'b1, 1'b1, 1'b1, 8'd30, TAIL_STOP},  // start while open is ignored
		'{8'h80, 1'b1, 1'b1, 1'b1, 8'd32, TAIL_STOP},  // full run
		'{8'h01, 1'b1, 1'b0, 1'b1, 8'd28, TAIL_OPEN1},
		'{8'h55, 1'b0, 1'b0, 1'b0, 8'd0,  TAIL_NONE},
		'{8'hAA, 1'b0, 1'b1, 1'b0, 8'd0,  TAIL_NONE},
		'{8'h3C, 1'b0, 1'b0, 1'b1, 8'd0,  TAIL_NONE},  // dropped again
		'{8'h7F, 1'b1, 1'b0, 1'b0, 8'd0,  TAIL_NONE},
		'{8'hFE, 1'b0, 1'b0, 1'b0, 8'd0,  TAIL_NONE},
		'{8'hC3, 1'b1, 1'b0, 1'b0, 8'd0,  TAIL_NONE},
		'{8'h18, 1'b0, 1'b1, 1'b0, 8'd0,  TAIL_NONE},
		'{8'hFF, 1'b1, 1'b1, 1'b1, 8'd32, TAIL_STOP},
		'{8'h00, 1'b1, 1'b1, 1'b1, 8'd32, TAIL_STOP},
		'{8'h5A, 1'b0, 1'b1, 1'b1, 8'd0,  TAIL_NONE},  // dropped, stop flag ignored
		'{8'h81, 1'b1, 1'b0, 1'b0, 8'd0,  TAIL_NONE},
		'{8'h42, 1'b0, 1'b1, 1'b0, 8'd0,  TAIL_NONE}
	};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = HOLD_RESET;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] data_byte
	logic [1:0]  s_tuser   = '0;   // [0] send_start, [1] send_stop
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [0] scl_level, [1] sda_level, [2] sda_released, [7:3] zero
	logic        m_tlast;          // last_phase

	// Predicted line state and pending phases
	logic        bus_open = 1'b0;
	logic        sda_now  = 1'b1;
	logic        scl_now  = 1'b1;
	phase_exp_t  phase_q[$];

	int unsigned errors   = 0;
	int unsigned cur_hold = 32'(HOLD_RESET);
	logic        tx_burst = 1'b0;

	i2c_master_write_bitbang_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Queue one phase from the current latches
	function automatic void put_phase(input logic rel, input logic last);
		phase_exp_t e;
		e.pins.scl  = scl_now;
		e.pins.sda  = rel ? 1'b1 : sda_now;
		e.pins.rel  = rel;
		e.pins.last = last;
		e.typed     = 1'b0;
		e.typed_len = '0;
		phase_q.push_back(e);
	endfunction

	// Phase run for one accepted byte; returns the number of phases queued
	function automatic int plan_phases(input logic [7:0] b, input logic st, input logic sp);
		int n0;
		n0 = phase_q.size();
		if (!bus_open) begin
			if (!st)
				return 0;
			// start: SDA falls with SCL high, then SCL falls
			sda_now = 1'b0;
			put_phase(1'b0, 1'b0);
			scl_now = 1'b0;
			put_phase(1'b0, 1'b0);
			bus_open = 1'b1;
		end
		for (int i = 7; i >= 0; i--) begin
			sda_now = b[i];
			put_phase(1'b0, 1'b0);
			scl_now = 1'b1;
			put_phase(1'b0, 1'b0);
			scl_now = 1'b0;
			put_phase(1'b0, 1'b0);
		end
		// acknowledge slot, SDA released while SCL is high
		scl_now = 1'b1;
		put_phase(1'b1, 1'b0);
		scl_now = 1'b0;
		put_phase(1'b0, !sp);
		if (sp) begin
			put_phase(1'b0, 1'b0);
			sda_now = 1'b0;
			put_phase(1'b0, 1'b0);
			scl_now = 1'b1;
			put_phase(1'b0, 1'b0);
			sda_now = 1'b1;
			put_phase(1'b0, 1'b1);
			bus_open = 1'b0;
		end
		return phase_q.size() - n0;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] e,
			input logic [7:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			errors++;
		end
	endfunction

	// Offer one byte, wait for its transfer, then predict its phases
	task automatic offer_byte(input logic [7:0] b, input logic st, input logic sp,
			input logic typed, input logic [7:0] typed_len, input pins_t tail,
			output int n);
		int unsigned gap;
		phase_exp_t  e;
		if ($urandom_range(0, 15) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= {sp, st};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n = plan_phases(b, st, sp);
		// typed rows take their final phase and count straight from the table
		if (typed && n != 0) begin
			e = phase_q.pop_back();
			e.pins      = tail;
			e.typed     = 1'b1;
			e.typed_len = typed_len;
			phase_q.push_back(e);
		end
	endtask

	// Mostly well-formed frames of one to several bytes, with dropped bytes and stray starts
	task automatic random_burst(input int unsigned want);
		int unsigned taken;
		int          n;
		logic [7:0]  b;
		logic        st;
		logic        sp;
		taken = 0;
		while (taken < want) begin
			b = 8'($urandom_range(0, 255));
			if (!bus_open) begin
				st = ($urandom_range(0, 7) != 0);
				sp = 1'($urandom_range(0, 1));
			end else begin
				st = ($urandom_range(0, 6) == 0);
				sp = ($urandom_range(0, 3) == 0);
			end
			offer_byte(b, st, sp, 1'b0, 8'd0, TAIL_NONE, n);
			if (n != 0)
				taken++;
		end
	endtask

	task automatic write_hold(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_hold = 32'(v);
		@(posedge clk);
	endtask

	// Let every phase drain, then give a dropped byte time to clear the sequencer
	task automatic drain_phases();
		s_tvalid <= 1'b0;
		while (phase_q.size() != 0)
			@(posedge clk);
		repeat (4 * cur_hold + 40) @(posedge clk);
	endtask

	// Stimulus and register settings
	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer_byte(DIRECTED[i].data_byte, DIRECTED[i].send_start, DIRECTED[i].send_stop,
				DIRECTED[i].typed, DIRECTED[i].typed_len, DIRECTED[i].typed_tail, n);
		drain_phases();

		write_hold(16'd1);
		random_burst(34);
		drain_phases();

		// top of range written and replaced before any byte goes out
		write_hold(16'hFFFF);
		write_hold(16'd2);
		random_burst(33);
		drain_phases();

		write_hold(16'($urandom_range(3, 6)));
		random_burst(33);
		drain_phases();

		write_hold(16'd16);
		random_burst(30);
		drain_phases();

		if (errors == 0)
			$display("i2c_master_write_bitbang_top_tb: done, clean");
		else
			$display("i2c_master_write_bitbang_top_tb: done, errors");
		$finish;
	end

	// Phase receiver: random stalls, bursts, and one long hold-off to back up the input
	initial begin
		int unsigned stall;
		int unsigned phases_seen;
		int unsigned phase_in_item;
		logic        rx_burst;
		logic        held_off;
		phase_exp_t  e;
		phases_seen   = 0;
		phase_in_item = 0;
		rx_burst      = 1'b0;
		held_off      = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 11);
			if (!held_off && phases_seen >= 1200) begin
				stall    = 600;
				held_off = 1'b1;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			phases_seen++;
			if (phase_q.size() == 0) begin
				$error("unexpected phase: scl %0d sda %0d rel %0d last %0d",
					m_tdata[0], m_tdata[1], m_tdata[2], m_tlast);
				errors++;
			end else begin
				e = phase_q.pop_front();
				phase_in_item++;
				check_field("scl_level", 8'(e.pins.scl), 8'(m_tdata[0]));
				check_field("sda_level", 8'(e.pins.sda), 8'(m_tdata[1]));
				check_field("sda_released", 8'(e.pins.rel), 8'(m_tdata[2]));
				check_field("last_phase", 8'(e.pins.last), 8'(m_tlast));
				check_field("tdata padding", 8'd0, 8'(m_tdata[7:3]));
				if (e.pins.last) begin
					if (e.typed)
						check_field("phases per byte", e.typed_len, 8'(phase_in_item));
					phase_in_item = 0;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("i2c_master_write_bitbang_top_tb: done, errors");
		$finish;
	end

endmodule
